// File: sv/ippmbp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ippmbp_pkg;

  // Parse phases of the message walker
  typedef enum logic [3:0] {
    PH_HEADER,
    PH_GROUP,
    PH_VTAG,
    PH_NLEN_HI,
    PH_NLEN_LO,
    PH_NAME,
    PH_VLEN_HI,
    PH_VLEN_LO,
    PH_VALUE,
    PH_DONE,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    EV_HEADER,
    EV_NAME_BYTE,
    EV_VALUE_BYTE,
    EV_VALUE_DONE,
    EV_GROUP_START,
    EV_MSG_END,
    EV_ERROR
  } event_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_BAD_GROUP,
    ERR_EARLY_END,
    ERR_BAD_LENGTH
  } error_code_e;

  localparam logic [7:0] TAG_END = 8'h03;

  // Value tags of fixed-size types and the length each must declare
  localparam logic [7:0] TAG_INTEGER    = 8'h21;
  localparam logic [7:0] TAG_BOOLEAN    = 8'h22;
  localparam logic [7:0] TAG_ENUM       = 8'h23;
  localparam logic [7:0] TAG_DATETIME   = 8'h31;
  localparam logic [7:0] TAG_RESOLUTION = 8'h32;
  localparam logic [7:0] TAG_RANGE      = 8'h33;

  localparam logic [15:0] LEN_INTEGER    = 16'd4;
  localparam logic [15:0] LEN_BOOLEAN    = 16'd1;
  localparam logic [15:0] LEN_DATETIME   = 16'd11;
  localparam logic [15:0] LEN_RESOLUTION = 16'd9;
  localparam logic [15:0] LEN_RANGE      = 16'd8;

  localparam logic [2:0] HDR_LAST = 3'd7;

  typedef struct packed {
    event_kind_e kind;
    error_code_e err;
    logic [7:0]  group_tag;
    logic [7:0]  type_tag;
    logic        new_attribute;
    logic [15:0] declared_len;
    logic [7:0]  data_byte;
    logic [31:0] value_word;
    logic [7:0]  version_major;
    logic [7:0]  version_minor;
    logic [15:0] op_or_status;
  } result_t;

endpackage

`default_nettype wire

// File: sv/ipp_message_byte_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// IPP binary message parser, one byte per item. The 8-byte header is
// collected and reported once, then group tags, value tags, name and value
// lengths, names and values are walked, giving at most one result item per
// input item: header, name byte, value byte, value done (last four value
// bytes big-endian), group start, message end, or an error (bad group tag,
// stream ended early, wrong length for a fixed-size type). Throughput is one
// item per clock while the result channel does not stall; an item passes an
// input register, the per-byte step logic and the result register before its
// result reaches the output ports. A stalled result register holds back the
// input register only, so one extra item can still be absorbed. After message
// end or an error, bytes are dropped silently until stream_end, which rearms
// the parser.
module ipp_message_byte_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_byte_i,
  input  wire logic        stream_end_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_kind_o,
  output logic [1:0]       error_code_o,
  output logic [7:0]       group_tag_o,
  output logic [7:0]       type_tag_o,
  output logic             new_attribute_o,
  output logic [15:0]      declared_len_o,
  output logic [7:0]       data_byte_o,
  output logic [31:0]      value_word_o,
  output logic [7:0]       version_major_o,
  output logic [7:0]       version_minor_o,
  output logic [15:0]      op_or_status_o
);
  import ippmbp_pkg::*;

  // input register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_end_q;

  logic       out_free;
  logic       s1_fire;
  logic       in_take;
  logic       step_valid;
  result_t    step_res;
  result_t    out_res;

  // The held item is consumed whenever the result register can take it,
  // whether or not it produces a result.
  assign s1_fire    = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_byte_q <= in_byte_i;
      s1_end_q  <= stream_end_i;
    end
  end

  ippmbp_step u_step (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .byte_i      (s1_byte_q),
    .end_i       (s1_end_q),
    .res_valid_o (step_valid),
    .res_o       (step_res)
  );

  ippmbp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .res_valid_i (step_valid),
    .res_i       (step_res),
    .stall_i     (out_stall_i),
    .valid_o     (out_valid_o),
    .res_o       (out_res),
    .free_o      (out_free)
  );

  assign event_kind_o    = out_res.kind;
  assign error_code_o    = out_res.err;
  assign group_tag_o     = out_res.group_tag;
  assign type_tag_o      = out_res.type_tag;
  assign new_attribute_o = out_res.new_attribute;
  assign declared_len_o  = out_res.declared_len;
  assign data_byte_o     = out_res.data_byte;
  assign value_word_o    = out_res.value_word;
  assign version_major_o = out_res.version_major;
  assign version_minor_o = out_res.version_minor;
  assign op_or_status_o  = out_res.op_or_status;

endmodule

`default_nettype wire

// File: sv/ippmbp_step.sv
`timescale 1ns / 1ps
`default_nettype none

// Parser state and the per-byte step; state advances only on fire_i.
module ippmbp_step (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             fire_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             end_i,
  output logic                  res_valid_o,
  output ippmbp_pkg::result_t   res_o
);
  import ippmbp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  hcnt_q, hcnt_d;
  logic [55:0] hdr_q, hdr_d;
  logic [7:0]  group_q, group_d;
  logic [7:0]  vtag_q, vtag_d;
  logic [15:0] dlen_q, dlen_d;
  logic [15:0] rem_q, rem_d;
  logic [31:0] acc_q, acc_d;
  logic        named_q, named_d;

  logic [15:0] len_full;
  logic [15:0] need_len;
  logic        len_bad;
  logic        grp_end;

  function automatic phase_e group_phase(input logic [7:0] tag);
    phase_e ph;
    if (tag == TAG_END) begin
      ph = PH_DONE;
    end else if (!tag[7] && (tag[6:4] != 3'd0)) begin
      ph = PH_ERROR;
    end else begin
      ph = PH_VTAG;
    end
    return ph;
  endfunction

  always_comb begin
    unique case (vtag_q)
      TAG_INTEGER, TAG_ENUM: need_len = LEN_INTEGER;
      TAG_BOOLEAN:           need_len = LEN_BOOLEAN;
      TAG_RANGE:             need_len = LEN_RANGE;
      TAG_RESOLUTION:        need_len = LEN_RESOLUTION;
      TAG_DATETIME:          need_len = LEN_DATETIME;
      default:               need_len = 16'd0;
    endcase
  end

  assign len_full = {dlen_q[15:8], byte_i};
  assign len_bad  = (need_len != 16'd0) && (len_full != need_len);
  assign grp_end  = byte_i[7] || (byte_i[7:4] == 4'd0);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
      if (end_i) begin
        phase_d = PH_HEADER;
      end
    end else if (end_i) begin
      phase_d = PH_ERROR;
    end else begin
      unique case (phase_q)
        PH_HEADER:  phase_d = (hcnt_q == HDR_LAST) ? PH_GROUP : PH_HEADER;
        PH_GROUP:   phase_d = group_phase(byte_i);
        PH_VTAG:    phase_d = grp_end ? group_phase(byte_i) : PH_NLEN_HI;
        PH_NLEN_HI: phase_d = PH_NLEN_LO;
        PH_NLEN_LO: phase_d = ({rem_q[15:8], byte_i} != 16'd0) ? PH_NAME : PH_VLEN_HI;
        PH_NAME:    phase_d = (rem_q == 16'd1) ? PH_VLEN_HI : PH_NAME;
        PH_VLEN_HI: phase_d = PH_VLEN_LO;
        PH_VLEN_LO: begin
          if (len_bad) begin
            phase_d = PH_ERROR;
          end else if (len_full == 16'd0) begin
            phase_d = PH_VTAG;
          end else begin
            phase_d = PH_VALUE;
          end
        end
        PH_VALUE:   phase_d = (rem_q == 16'd1) ? PH_VTAG : PH_VALUE;
        default:    phase_d = phase_q;
      endcase
    end
  end

  // Datapath registers and the result
  always_comb begin
    hcnt_d  = hcnt_q;
    hdr_d   = hdr_q;
    group_d = group_q;
    vtag_d  = vtag_q;
    dlen_d  = dlen_q;
    rem_d   = rem_q;
    acc_d   = acc_q;
    named_d = named_q;

    res_valid_o         = 1'b0;
    res_o.kind          = EV_HEADER;
    res_o.err           = ERR_NONE;
    res_o.data_byte     = 8'd0;
    res_o.value_word    = 32'd0;
    res_o.version_major = 8'd0;
    res_o.version_minor = 8'd0;
    res_o.op_or_status  = 16'd0;

    if (phase_q == PH_DONE || phase_q == PH_ERROR) begin
      if (end_i) begin
        hcnt_d  = 3'd0;
        hdr_d   = 56'd0;
        group_d = 8'd0;
        vtag_d  = 8'd0;
        dlen_d  = 16'd0;
        rem_d   = 16'd0;
        acc_d   = 32'd0;
        named_d = 1'b0;
      end
    end else if (end_i) begin
      res_valid_o = 1'b1;
      res_o.kind  = EV_ERROR;
      res_o.err   = ERR_EARLY_END;
    end else begin
      unique case (phase_q)
        PH_HEADER: begin
          hdr_d  = {hdr_q[47:0], byte_i};
          hcnt_d = hcnt_q + 3'd1;
          if (hcnt_q == HDR_LAST) begin
            res_valid_o         = 1'b1;
            res_o.kind          = EV_HEADER;
            res_o.value_word    = {hdr_q[23:0], byte_i};
            res_o.version_major = hdr_q[55:48];
            res_o.version_minor = hdr_q[47:40];
            res_o.op_or_status  = hdr_q[39:24];
          end
        end
        PH_GROUP, PH_VTAG: begin
          if (phase_q == PH_GROUP || grp_end) begin
            group_d     = byte_i;
            res_valid_o = 1'b1;
            unique case (group_phase(byte_i))
              PH_DONE:  res_o.kind = EV_MSG_END;
              PH_ERROR: begin
                res_o.kind = EV_ERROR;
                res_o.err  = ERR_BAD_GROUP;
              end
              default:  res_o.kind = EV_GROUP_START;
            endcase
          end else begin
            vtag_d  = byte_i;
            dlen_d  = 16'd0;
            named_d = 1'b0;
          end
        end
        PH_NLEN_HI: rem_d = {byte_i, 8'd0};
        PH_NLEN_LO: begin
          rem_d   = {rem_q[15:8], byte_i};
          named_d = ({rem_q[15:8], byte_i} != 16'd0);
        end
        PH_NAME: begin
          rem_d           = rem_q - 16'd1;
          res_valid_o     = 1'b1;
          res_o.kind      = EV_NAME_BYTE;
          res_o.data_byte = byte_i;
        end
        PH_VLEN_HI: dlen_d = {byte_i, 8'd0};
        PH_VLEN_LO: begin
          dlen_d = len_full;
          if (len_bad) begin
            res_valid_o = 1'b1;
            res_o.kind  = EV_ERROR;
            res_o.err   = ERR_BAD_LENGTH;
          end else begin
            acc_d = 32'd0;
            rem_d = len_full;
            if (len_full == 16'd0) begin
              res_valid_o = 1'b1;
              res_o.kind  = EV_VALUE_DONE;
            end
          end
        end
        PH_VALUE: begin
          acc_d           = {acc_q[23:0], byte_i};
          rem_d           = rem_q - 16'd1;
          res_valid_o     = 1'b1;
          res_o.data_byte = byte_i;
          if (rem_q == 16'd1) begin
            res_o.kind       = EV_VALUE_DONE;
            res_o.value_word = {acc_q[23:0], byte_i};
          end else begin
            res_o.kind = EV_VALUE_BYTE;
          end
        end
        default: ;
      endcase
    end

    // Context fields reflect the state as left by this byte
    res_o.group_tag     = group_d;
    res_o.type_tag      = vtag_d;
    res_o.new_attribute = named_d;
    res_o.declared_len  = dlen_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      hcnt_q  <= 3'd0;
      hdr_q   <= 56'd0;
      group_q <= 8'd0;
      vtag_q  <= 8'd0;
      dlen_q  <= 16'd0;
      rem_q   <= 16'd0;
      acc_q   <= 32'd0;
      named_q <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      hcnt_q  <= hcnt_d;
      hdr_q   <= hdr_d;
      group_q <= group_d;
      vtag_q  <= vtag_d;
      dlen_q  <= dlen_d;
      rem_q   <= rem_d;
      acc_q   <= acc_d;
      named_q <= named_d;
    end
  end

endmodule

`default_nettype wire

// File: sv/ippmbp_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

// Result register; free_o says a new result may be loaded this cycle.
module ippmbp_out_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 load_i,
  input  wire logic                 res_valid_i,
  input  wire ippmbp_pkg::result_t  res_i,
  input  wire logic                 stall_i,
  output logic                      valid_o,
  output ippmbp_pkg::result_t       res_o,
  output logic                      free_o
);
  import ippmbp_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_valid_i;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
